>>> rtl/tli_pkg.sv
package tli_pkg;

  typedef enum logic [3:0] {
    ST_BUSY       = 4'd0,
    ST_OUTPUT     = 4'd1,
    ST_DONE       = 4'd2,
    ST_IDLE       = 4'd3,
    ST_EMPTY      = 4'd4,
    ST_NEGPOS     = 4'd5,
    ST_UNCLOSED   = 4'd6,
    ST_UNOPENED   = 4'd7,
    ST_TAPE_END   = 4'd8,
    ST_STACK_FULL = 4'd9,
    ST_STOPPED    = 4'd10,
    ST_LOADED     = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_START = 2'd1,
    K_STEP  = 2'd2,
    K_STOP  = 2'd3
  } kind_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam int LEN_BITS = 13;
  localparam int POS_BITS = 13;

endpackage

>>> rtl/tli_ram.sv
module tli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tape_language_interpreter_unit.sv
// channel  direction  handshake            payload
// cfg      in         cfg_we               cfg_data (program length)
// in       in         in_valid / in_ready  kind, prog_addr, prog_char
// out      out        out_valid / out_ready status, out_char, position
//
// load, start, stop and steps that need no memory read answer in the cycle after
// acceptance; a step that runs or skips a character passes through S_EXEC (the program ram,
// and when running the tape and loop stack rams, are read on acceptance; S_EXEC applies the result).
// the tape needs no clearing pass: a fill count marks how many cells this run wrote,
// cells at or above it read as zero. synchronous reset clears all control state.
// a new word is taken while a result waits only if that result leaves the same cycle.
module tape_language_interpreter_unit #(
  parameter int TAPE_DEPTH  = 32768,
  parameter int PROG_DEPTH  = 4096,
  parameter int STACK_DEPTH = 128,
  parameter int CELL_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tli_pkg::LEN_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [11:0]                   prog_addr,
  input  logic [7:0]                    prog_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    status,
  output logic [7:0]                    out_char,
  output logic [tli_pkg::POS_BITS-1:0]  position
);

  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int PCW = PAW + 1;
  localparam int TAW = $clog2(TAPE_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SDW = SAW + 1;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                        state, state_next;
  logic [tli_pkg::LEN_BITS-1:0]  program_length;
  logic [PCW-1:0]                pc, pc_next, run_len, run_len_next;
  logic [TAW-1:0]                dp, dp_next;
  logic [TAW:0]                  fill, fill_next;
  logic [SDW-1:0]                depth, depth_next;
  logic [PCW-1:0]                skip_depth, skip_depth_next;
  logic                          running, running_next, skipping, skipping_next;
  logic                          ov_next;
  tli_pkg::status_t              st_q, st_next;
  logic [7:0]                    oc_q, oc_next;
  logic [tli_pkg::POS_BITS-1:0]  pos_q, pos_next;

  logic                 prog_we, prog_re;
  logic [PAW-1:0]       prog_waddr, prog_raddr;
  logic [7:0]           prog_rdata;
  logic                 tape_we, tape_re;
  logic [CELL_BITS-1:0] tape_wdata, tape_rdata, cur_cell, cell_new;
  logic                 stack_we, stack_re;
  logic [SAW-1:0]       stack_waddr, stack_raddr;
  logic [PAW-1:0]       stack_rdata;
  logic [PCW-1:0]       pc_inc;

  tli_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
    .clk(clk), .we(prog_we), .waddr(prog_waddr), .wdata(prog_char),
    .re(prog_re), .raddr(prog_raddr), .rdata(prog_rdata)
  );

  tli_ram #(.WIDTH(CELL_BITS), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk(clk), .we(tape_we), .waddr(dp), .wdata(tape_wdata),
    .re(tape_re), .raddr(dp), .rdata(tape_rdata)
  );

  tli_ram #(.WIDTH(PAW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(pc[PAW-1:0]),
    .re(stack_re), .raddr(stack_raddr), .rdata(stack_rdata)
  );

  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign status     = st_q;
  assign out_char   = oc_q;
  assign position   = pos_q;
  assign prog_waddr = PAW'(prog_addr);
  assign stack_waddr = depth[SAW-1:0];
  assign stack_raddr = SAW'(depth - SDW'(1));
  assign pc_inc     = pc + PCW'(1);
  // cells beyond the fill count belong to an earlier run
  assign cur_cell   = ({1'b0, dp} < fill) ? tape_rdata : '0;

  always_comb begin
    state_next      = state;
    pc_next         = pc;
    run_len_next    = run_len;
    dp_next         = dp;
    fill_next       = fill;
    depth_next      = depth;
    skip_depth_next = skip_depth;
    running_next    = running;
    skipping_next   = skipping;
    ov_next         = out_valid && !out_ready;
    st_next         = st_q;
    oc_next         = oc_q;
    pos_next        = pos_q;
    prog_we         = 1'b0;
    prog_re         = 1'b0;
    prog_raddr      = pc[PAW-1:0];
    tape_we         = 1'b0;
    tape_re         = 1'b0;
    tape_wdata      = cur_cell;
    cell_new        = cur_cell;
    stack_we        = 1'b0;
    stack_re        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ov_next  = 1'b1;
          oc_next  = '0;
          pos_next = '0;
          st_next  = tli_pkg::ST_BUSY;
          unique case (tli_pkg::kind_t'(kind))
            tli_pkg::K_LOAD: begin
              prog_we = 32'(prog_addr) < 32'(PROG_DEPTH);
              st_next = tli_pkg::ST_LOADED;
            end
            tli_pkg::K_START: begin
              pc_next         = '0;
              dp_next         = '0;
              fill_next       = '0;
              depth_next      = '0;
              skip_depth_next = '0;
              skipping_next   = 1'b0;
              run_len_next    = (32'(program_length) > 32'(PROG_DEPTH)) ?
                                PCW'(PROG_DEPTH) : PCW'(program_length);
              if (program_length == '0) begin
                running_next = 1'b0;
                st_next      = tli_pkg::ST_EMPTY;
              end else begin
                running_next = 1'b1;
              end
            end
            tli_pkg::K_STEP: begin
              if (!running) begin
                st_next = tli_pkg::ST_IDLE;
              end else if (skipping) begin
                if (pc_inc >= run_len) begin
                  running_next  = 1'b0;
                  skipping_next = 1'b0;
                  st_next       = tli_pkg::ST_UNCLOSED;
                  pos_next      = tli_pkg::POS_BITS'(run_len);
                end else begin
                  pc_next    = pc_inc;
                  prog_re    = 1'b1;
                  prog_raddr = pc_inc[PAW-1:0];
                  ov_next    = 1'b0;
                  state_next = S_EXEC;
                end
              end else if (pc >= run_len) begin
                running_next = 1'b0;
                if (depth != '0) begin
                  st_next  = tli_pkg::ST_UNCLOSED;
                  pos_next = tli_pkg::POS_BITS'(run_len);
                end else begin
                  st_next = tli_pkg::ST_DONE;
                end
              end else begin
                prog_re    = 1'b1;
                tape_re    = 1'b1;
                stack_re   = 1'b1;
                ov_next    = 1'b0;
                state_next = S_EXEC;
              end
            end
            tli_pkg::K_STOP: begin
              running_next  = 1'b0;
              skipping_next = 1'b0;
              st_next       = tli_pkg::ST_STOPPED;
            end
          endcase
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        ov_next    = 1'b1;
        oc_next    = '0;
        pos_next   = '0;
        st_next    = tli_pkg::ST_BUSY;
        if (skipping) begin
          if (prog_rdata == tli_pkg::CH_CLOSE) begin
            skip_depth_next = skip_depth - PCW'(1);
          end else if (prog_rdata == tli_pkg::CH_OPEN) begin
            skip_depth_next = skip_depth + PCW'(1);
          end
          if (skip_depth_next == '0) begin
            skipping_next = 1'b0;
            pc_next       = pc_inc;
          end
        end else begin
          pc_next = pc_inc;
          unique case (prog_rdata)
            tli_pkg::CH_PLUS:  cell_new = cur_cell + CELL_BITS'(1);
            tli_pkg::CH_MINUS: cell_new = cur_cell - CELL_BITS'(1);
            tli_pkg::CH_RIGHT: begin
              if (32'(dp) == TAPE_DEPTH - 1) begin
                running_next = 1'b0;
                st_next      = tli_pkg::ST_TAPE_END;
                pos_next     = tli_pkg::POS_BITS'(pc);
              end else begin
                dp_next = dp + TAW'(1);
              end
            end
            tli_pkg::CH_LEFT: begin
              if (dp == '0) begin
                running_next = 1'b0;
                st_next      = tli_pkg::ST_NEGPOS;
                pos_next     = tli_pkg::POS_BITS'(pc);
              end else begin
                dp_next = dp - TAW'(1);
              end
            end
            tli_pkg::CH_DOT: begin
              st_next = tli_pkg::ST_OUTPUT;
              oc_next = cur_cell[7:0];
            end
            tli_pkg::CH_OPEN: begin
              if (cur_cell != '0) begin
                if (32'(depth) >= STACK_DEPTH) begin
                  running_next = 1'b0;
                  st_next      = tli_pkg::ST_STACK_FULL;
                  pos_next     = tli_pkg::POS_BITS'(pc);
                end else begin
                  stack_we   = 1'b1;
                  depth_next = depth + SDW'(1);
                end
              end else begin
                // stay on the bracket, later steps scan forward
                skipping_next   = 1'b1;
                skip_depth_next = PCW'(1);
                pc_next         = pc;
              end
            end
            tli_pkg::CH_CLOSE: begin
              if (depth == '0) begin
                running_next = 1'b0;
                st_next      = tli_pkg::ST_UNOPENED;
                pos_next     = tli_pkg::POS_BITS'(pc);
              end else begin
                depth_next = depth - SDW'(1);
                if (cur_cell != '0) begin
                  pc_next = PCW'(stack_rdata);
                end
              end
            end
            default: ;
          endcase
          // write the cell back on every executed character so the fill count stays exact
          tape_we    = 1'b1;
          tape_wdata = cell_new;
          if ({1'b0, dp} == fill) begin
            fill_next = fill + (TAW+1)'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      program_length <= '0;
      pc             <= '0;
      run_len        <= '0;
      dp             <= '0;
      fill           <= '0;
      depth          <= '0;
      skip_depth     <= '0;
      running        <= 1'b0;
      skipping       <= 1'b0;
      out_valid      <= 1'b0;
      st_q           <= tli_pkg::ST_BUSY;
      oc_q           <= '0;
      pos_q          <= '0;
    end else begin
      if (cfg_we) begin
        program_length <= cfg_data;
      end
      state      <= state_next;
      pc         <= pc_next;
      run_len    <= run_len_next;
      dp         <= dp_next;
      fill       <= fill_next;
      depth      <= depth_next;
      skip_depth <= skip_depth_next;
      running    <= running_next;
      skipping   <= skipping_next;
      out_valid  <= ov_next;
      st_q       <= st_next;
      oc_q       <= oc_next;
      pos_q      <= pos_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_covers_pointer: assert property (@(posedge clk) disable iff (rst)
    running |-> ({1'b0, dp} <= fill))
    else $error("data pointer beyond fill count");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= STACK_DEPTH)
    else $error("loop stack depth overflow");

  a_skip_in_run: assert property (@(posedge clk) disable iff (rst)
    skipping |-> running)
    else $error("skipping outside a run");

  a_exec_answers: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> out_valid && state == S_IDLE)
    else $error("executed step gave no word");
`endif

endmodule
